### sv/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// Used by ole_cell, ole_ctrl, ordered_list_engine and ole_checker; no dependencies.
package ole_pkg;

    // Request and result field widths
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int ENT_W      = 5;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    // Result tdata bit positions
    localparam int M_STAT_LSB  = 0;
    localparam int M_ELEM_LSB  = 2;
    localparam int M_ENT_LSB   = 34;
    localparam int M_EMPTY_BIT = 39;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT_AT = 3'd0,
        FN_APPEND    = 3'd1,
        FN_REM_VALUE = 3'd2,
        FN_REM_AT    = 3'd3,
        FN_REVERSE   = 3'd4,
        FN_CLEAR     = 3'd5,
        FN_READ_OUT  = 3'd6
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    // Where a cell takes its next value from
    typedef enum logic [1:0] {
        SRC_HOLD,
        SRC_LEFT,
        SRC_RIGHT,
        SRC_FILL
    } cell_src_t;

endpackage

### sv/ordered_list_engine.sv
// Ordered list engine top level: request unpacking, the ole_cell row and ole_ctrl.
// Depends on ole_pkg, ole_cell and ole_ctrl.
//
// Bounded ordered list of up to DEPTH signed words held in a row of cells, one
// entry per cell. A request is taken only while the engine is idle. Insert,
// append, remove at, clear and unused codes pass through the exec and done
// states. Remove value and reverse on a non-empty list also pass through the
// scan state, and read out offers its entries from the read state: these walk
// the list through the cell row one entry per cycle, rotating it past cell 0;
// stalls on m_tready hold read out. Each result sits in an output register, so
// a new request is taken while the last result still waits.
module ordered_list_engine #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func[2:0], position[10:3], value[42:11], zero fill[47:43]
    input  logic [ole_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], element[33:2], entries[38:34], is_empty[39]
    output logic [ole_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    logic [VALUE_BITS-1:0]   cell_q [DEPTH];
    ole_pkg::cell_src_t      cell_src [DEPTH];
    logic [VALUE_BITS-1:0]   fill;

    ole_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_func     (s_tdata[2:0]),
        .s_position (s_tdata[10:3]),
        .s_value    (s_tdata[42:11]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .head       (cell_q[0]),
        .fill       (fill),
        .cell_src   (cell_src)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ole_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .src     (cell_src[i]),
            .left_q  (cell_q[(i == 0) ? 0 : i - 1]),
            .right_q (cell_q[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
            .fill    (fill),
            .q       (cell_q[i])
        );
    end

endmodule

### sv/ole_cell.sv
// One entry of the list row: holds a word, loads from a neighbor or the fill bus.
// Depends on ole_pkg.
module ole_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    aclk,
    input  ole_pkg::cell_src_t      src,
    input  logic [VALUE_BITS-1:0]   left_q,
    input  logic [VALUE_BITS-1:0]   right_q,
    input  logic [VALUE_BITS-1:0]   fill,
    output logic [VALUE_BITS-1:0]   q
);

    logic [VALUE_BITS-1:0] q_reg;

    always_ff @(posedge aclk) begin
        case (src)
            ole_pkg::SRC_LEFT:  q_reg <= left_q;
            ole_pkg::SRC_RIGHT: q_reg <= right_q;
            ole_pkg::SRC_FILL:  q_reg <= fill;
            default:            q_reg <= q_reg;
        endcase
    end

    assign q = q_reg;

endmodule

### sv/ole_ctrl.sv
// Sequencer for the ordered list engine: request decode, count, cell steering
// and the result register. Depends on ole_pkg; drives the ole_cell row.
module ole_ctrl #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ole_pkg::FUNC_W-1:0]      s_func,
    input  logic [ole_pkg::POS_W-1:0]       s_position,
    input  logic [ole_pkg::VAL_W-1:0]       s_value,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ole_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic [VALUE_BITS-1:0]           head,
    output logic [VALUE_BITS-1:0]           fill,
    output ole_pkg::cell_src_t              cell_src [DEPTH]
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

    ole_pkg::state_t                state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  span_reg, span_next;
    logic [CW-1:0]                  steps_reg, steps_next;
    ole_pkg::func_t                 func_reg, func_next;
    logic [ole_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [VALUE_BITS-1:0]          val_reg, val_next;
    ole_pkg::status_t               stat_reg, stat_next;

    logic                           m_valid_reg;
    ole_pkg::status_t               m_status_reg;
    logic [ole_pkg::VAL_W-1:0]      m_element_reg;
    logic [ole_pkg::ENT_W-1:0]      m_entries_reg;
    logic                           m_empty_reg;
    logic                           m_last_reg;

    logic                           out_free;
    logic                           out_load;
    ole_pkg::status_t               o_status;
    logic [ole_pkg::VAL_W-1:0]      o_element;
    logic                           o_last;
    logic                           rot_en;
    logic [CMPW-1:0]                pos_w, cnt_w, ins_pos;
    logic [IW-1:0]                  pidx;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ole_pkg::S_IDLE);
    assign pos_w    = CMPW'(pos_reg);
    assign cnt_w    = CMPW'(count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        span_next  = span_reg;
        steps_next = steps_reg;
        func_next  = func_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        out_load   = 1'b0;
        o_status   = ole_pkg::STAT_OK;
        o_element  = '0;
        o_last     = 1'b1;
        rot_en     = 1'b0;
        fill       = val_reg;
        ins_pos    = (func_reg == ole_pkg::FN_APPEND) ? cnt_w + CMPW'(1) : pos_w;
        pidx       = IW'(ins_pos - CMPW'(1));
        for (int i = 0; i < DEPTH; i++) begin
            cell_src[i] = ole_pkg::SRC_HOLD;
        end

        unique case (state_reg)
            ole_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = ole_pkg::func_t'(s_func);
                    pos_next   = s_position;
                    val_next   = VALUE_BITS'(s_value);
                    state_next = ole_pkg::S_EXEC;
                end
            end
            ole_pkg::S_EXEC: begin
                stat_next  = ole_pkg::STAT_OK;
                state_next = ole_pkg::S_DONE;
                span_next  = count_reg;
                steps_next = count_reg;
                unique case (func_reg) inside
                    ole_pkg::FN_INSERT_AT, ole_pkg::FN_APPEND: begin
                        if (ins_pos == '0 || ins_pos > cnt_w + CMPW'(1)) begin
                            stat_next = ole_pkg::STAT_BAD_POS;
                        end else if (count_reg == CW'(DEPTH)) begin
                            stat_next = ole_pkg::STAT_FULL;
                        end else begin
                            // open a gap at the position, push the tail right
                            for (int i = 0; i < DEPTH; i++) begin
                                if (IW'(i) > pidx) begin
                                    cell_src[i] = ole_pkg::SRC_LEFT;
                                end else if (IW'(i) == pidx) begin
                                    cell_src[i] = ole_pkg::SRC_FILL;
                                end
                            end
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ole_pkg::FN_REM_VALUE: begin
                        if (count_reg == '0) begin
                            stat_next = ole_pkg::STAT_EMPTY;
                        end else begin
                            state_next = ole_pkg::S_SCAN;
                        end
                    end
                    ole_pkg::FN_REM_AT: begin
                        if (pos_w == '0 || pos_w > cnt_w) begin
                            stat_next = ole_pkg::STAT_BAD_POS;
                        end else begin
                            // close the gap, pull the tail left
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                if (IW'(i) >= pidx) begin
                                    cell_src[i] = ole_pkg::SRC_RIGHT;
                                end
                            end
                            count_next = count_reg - CW'(1);
                        end
                    end
                    ole_pkg::FN_REVERSE: begin
                        if (count_reg != '0) begin
                            state_next = ole_pkg::S_SCAN;
                        end
                    end
                    ole_pkg::FN_CLEAR: begin
                        count_next = '0;
                    end
                    ole_pkg::FN_READ_OUT: begin
                        if (count_reg == '0) begin
                            stat_next = ole_pkg::STAT_EMPTY;
                        end else begin
                            state_next = ole_pkg::S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ole_pkg::S_SCAN: begin
                // head leaves the ring; kept heads re-enter at the ring's tail
                fill       = head;
                rot_en     = 1'b1;
                if (func_reg == ole_pkg::FN_REVERSE || head == val_reg) begin
                    span_next = span_reg - CW'(1);
                end
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1)) begin
                    if (func_reg == ole_pkg::FN_REM_VALUE) begin
                        count_next = span_next;
                    end
                    state_next = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_READ: begin
                fill = head;
                if (out_free) begin
                    out_load   = 1'b1;
                    o_element  = ole_pkg::VAL_W'(signed'(head));
                    o_last     = (steps_reg == CW'(1));
                    rot_en     = 1'b1;
                    steps_next = steps_reg - CW'(1);
                    if (steps_reg == CW'(1)) begin
                        state_next = ole_pkg::S_IDLE;
                    end
                end
            end
            ole_pkg::S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_status   = stat_reg;
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase

        // rotate the first span cells left by one, head into the last of them
        if (rot_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CW'(i) + CW'(1) < span_reg) begin
                    cell_src[i] = ole_pkg::SRC_RIGHT;
                end else if (CW'(i) + CW'(1) == span_reg) begin
                    cell_src[i] = ole_pkg::SRC_FILL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ole_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        span_reg  <= span_next;
        steps_reg <= steps_next;
        func_reg  <= func_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        if (out_load) begin
            m_status_reg  <= o_status;
            m_element_reg <= o_element;
            m_entries_reg <= ole_pkg::ENT_W'(count_reg);
            m_empty_reg   <= (count_reg == '0);
            m_last_reg    <= o_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_empty_reg, m_entries_reg, m_element_reg, m_status_reg};

endmodule

### sv/ole_checker.sv
// Port-level checks for ordered_list_engine, attached by bind.
// Depends on ole_pkg.
module ole_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ole_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ole_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);

    logic [ole_pkg::STAT_W-1:0] m_status;
    logic [ole_pkg::VAL_W-1:0]  m_element;
    logic [ole_pkg::ENT_W-1:0]  m_entries;
    logic                       m_empty;
    logic                       req_seen;

    assign m_status  = m_tdata[ole_pkg::M_STAT_LSB +: ole_pkg::STAT_W];
    assign m_element = m_tdata[ole_pkg::M_ELEM_LSB +: ole_pkg::VAL_W];
    assign m_entries = m_tdata[ole_pkg::M_ENT_LSB +: ole_pkg::ENT_W];
    assign m_empty   = m_tdata[ole_pkg::M_EMPTY_BIT];
    assign req_seen  = s_tvalid && s_tready && (s_tdata != '1);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_empty |-> m_entries == '0)
        else $error("empty list reports entries");

    // error results are single-result and carry no element
    a_err_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_status != ole_pkg::STAT_OK |-> m_element == '0 && m_tlast)
        else $error("error result carries element or lacks last");

    // the result is registered: a request taken while no result is pending does not raise m_tvalid at once
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        req_seen && !m_tvalid |=> !m_tvalid)
        else $error("result offered too early");

endmodule

bind ordered_list_engine ole_port_checker u_ole_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
